@@ rtl/tree_routing_node_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tree routing node controller
// Shared helpers for concurrent checks, clocked on i_clk, gated by reset.
// ----------------------------------------------------------------------------
`ifndef TREE_ROUTING_NODE_CONTROLLER_CORE_MACROS_SVH
`define TREE_ROUTING_NODE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define TRNC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/trnc_pkg.sv @@
// ----------------------------------------------------------------------------
// trnc_pkg
// Types, constants and helpers shared by the node controller modules.
// ----------------------------------------------------------------------------
package trnc_pkg;

    localparam int CHILD_SLOTS = 4;
    // power of two: node slot is the low address bits
    localparam int NODE_SLOTS  = 256;
    localparam int NODE_AW     = $clog2(NODE_SLOTS);
    localparam int CHILD_AW    = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
    localparam int CCNT_W      = $clog2(CHILD_SLOTS + 1);
    localparam int IDX_W       = (NODE_AW > CCNT_W) ? NODE_AW : CCNT_W;
    localparam int MAX_RES     = 6;
    localparam int QCNT_W      = $clog2(MAX_RES + 1);
    localparam int QIDX_W      = $clog2(MAX_RES);
    localparam int AGE_W       = 2;
    localparam int ADDR_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [AGE_W-1:0] AGE_FULL = 2'd3;

    // request types
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_BUTTON = 2'd1;
    localparam logic [1:0] REQ_BCAST  = 2'd2;
    localparam logic [1:0] REQ_UCAST  = 2'd3;

    // packet kinds
    localparam logic [3:0] K_DISCOVER  = 4'd0;
    localparam logic [3:0] K_HELLO_ORP = 4'd1;
    localparam logic [3:0] K_HELLO_CHD = 4'd2;
    localparam logic [3:0] K_ADOPT     = 4'd3;
    localparam logic [3:0] K_ACK       = 4'd4;
    localparam logic [3:0] K_ABANDON   = 4'd5;
    localparam logic [3:0] K_DATA      = 4'd6;
    localparam logic [3:0] K_OPEN      = 4'd7;
    localparam logic [3:0] K_CLOSE     = 4'd8;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE  = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] from_address;
        logic [3:0]        packet_kind;
        logic [ADDR_W-1:0] packet_source;
        logic [ADDR_W-1:0] packet_dest;
        logic [15:0]       packet_payload;
        logic [15:0]       sensor_value;
    } t_req;

    typedef struct packed {
        logic              send_valid;
        logic              is_broadcast;
        logic [ADDR_W-1:0] next_hop;
        logic [3:0]        out_kind;
        logic [ADDR_W-1:0] out_source;
        logic [ADDR_W-1:0] out_dest;
        logic [15:0]       out_payload;
        logic              valve_open;
        logic              parent_known;
        logic              last_result;
    } t_res;

    typedef struct packed {
        logic              bcast;
        logic [ADDR_W-1:0] hop;
        logic [3:0]        kind;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [15:0]       pay;
    } t_qent;

    typedef enum logic [4:0] {
        OP_NOP, OP_LATCH, OP_CLEAR, OP_EMIT_DATA, OP_AGE_RD, OP_AGE_WR,
        OP_CH_RD, OP_CH_CHK, OP_CH_END, OP_PAR_RD, OP_ABANDON, OP_DROP_END,
        OP_DISCOVER, OP_ROUND, OP_BCAST, OP_UNI, OP_UNI_HELLO, OP_RELAY,
        OP_DRAIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idx_rst;
    } t_cmd;

    typedef struct packed {
        logic       idx_end;
        logic       ch_done;
        logic       age_zero;
        logic       parent_valid;
        logic [1:0] req_type;
        logic [3:0] kind;
        logic       to_own;
        logic       to_server;
        logic       q_last;
    } t_stat;

    function automatic logic [NODE_AW-1:0] slot(input logic [ADDR_W-1:0] a);
        return a[NODE_AW-1:0];
    endfunction

endpackage

@@ rtl/trnc_ram.sv @@
// ----------------------------------------------------------------------------
// trnc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/trnc_dp.sv @@
// ----------------------------------------------------------------------------
// trnc_dp
// Datapath: config, node state, neighbour/route RAMs, result queue, output.
// ----------------------------------------------------------------------------
module trnc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [trnc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [15:0]                     i_cfg_wdata,
    input  trnc_pkg::t_req                  i_req,
    input  trnc_pkg::t_cmd                  i_cmd,
    output trnc_pkg::t_stat                 o_stat,
    output trnc_pkg::t_res                  o_res,
    output logic                            o_strobe
);

    localparam int AW = trnc_pkg::NODE_AW;
    localparam int DW = trnc_pkg::ADDR_W;

    logic [DW-1:0]                   r_own, r_server, r_parent;
    logic [1:0]                      r_round, n_round;
    logic                            r_has, r_valve;
    logic [DW-1:0]                   r_child [trnc_pkg::CHILD_SLOTS];
    logic [trnc_pkg::CCNT_W-1:0]     r_ccnt, r_kept;
    logic [trnc_pkg::IDX_W-1:0]      r_idx;
    trnc_pkg::t_req                  r_in;
    trnc_pkg::t_qent                 r_q [trnc_pkg::MAX_RES];
    logic [trnc_pkg::QCNT_W-1:0]     r_qcnt;
    logic [trnc_pkg::QIDX_W-1:0]     r_qrd;
    trnc_pkg::t_res                  r_res;
    logic                            r_strobe;

    logic                            age_we, age_re, rt_we, rt_re;
    logic [AW-1:0]                   age_wa, age_ra, rt_wa, rt_ra;
    logic [trnc_pkg::AGE_W-1:0]      age_wd, age_rd;
    logic [DW-1:0]                   rt_wd, rt_rd;

    logic [DW-1:0]                   cur_child;
    logic                            to_own, to_server, dup, room, q_last;
    logic                            e_valid;
    trnc_pkg::t_qent                 e_ent;

    assign cur_child = r_child[r_idx[trnc_pkg::CHILD_AW-1:0]];
    assign to_own    = (r_in.packet_dest == r_own);
    assign to_server = (r_in.packet_dest == r_server);
    assign room      = (r_ccnt < trnc_pkg::CCNT_W'(trnc_pkg::CHILD_SLOTS));
    assign n_round   = (r_round == 2'd2) ? 2'd0 : r_round + 2'd1;
    assign q_last    = (r_qcnt == '0) ||
                       (r_qrd == trnc_pkg::QIDX_W'(r_qcnt - trnc_pkg::QCNT_W'(1)));

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < trnc_pkg::CHILD_SLOTS; i++) begin
            if ((trnc_pkg::CCNT_W'(i) < r_ccnt) && (r_child[i] == r_in.packet_source)) begin
                dup = 1'b1;
            end
        end
    end

    trnc_ram #(.WIDTH(trnc_pkg::AGE_W), .DEPTH(trnc_pkg::NODE_SLOTS)) u_age (
        .i_clk(i_clk), .i_we(age_we), .i_waddr(age_wa), .i_wdata(age_wd),
        .i_re(age_re), .i_raddr(age_ra), .o_rdata(age_rd)
    );

    trnc_ram #(.WIDTH(DW), .DEPTH(trnc_pkg::NODE_SLOTS)) u_route (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_wa), .i_wdata(rt_wd),
        .i_re(rt_re), .i_raddr(rt_ra), .o_rdata(rt_rd)
    );

    // RAM port control
    always_comb begin
        age_we = 1'b0; age_wa = '0; age_wd = '0; age_re = 1'b0; age_ra = '0;
        rt_we  = 1'b0; rt_wa  = '0; rt_wd  = '0; rt_re  = 1'b0; rt_ra  = '0;
        case (i_cmd.op)
            trnc_pkg::OP_CLEAR: begin
                age_we = 1'b1;
                age_wa = r_idx[AW-1:0];
                rt_we  = 1'b1;
                rt_wa  = r_idx[AW-1:0];
            end
            trnc_pkg::OP_AGE_RD: begin
                age_re = 1'b1;
                age_ra = r_idx[AW-1:0];
            end
            trnc_pkg::OP_AGE_WR: begin
                age_we = 1'b1;
                age_wa = r_idx[AW-1:0];
                age_wd = (age_rd == '0) ? '0 : age_rd - trnc_pkg::AGE_W'(1);
            end
            trnc_pkg::OP_CH_RD: begin
                age_re = 1'b1;
                age_ra = trnc_pkg::slot(cur_child);
            end
            trnc_pkg::OP_PAR_RD: begin
                age_re = 1'b1;
                age_ra = trnc_pkg::slot(r_parent);
            end
            trnc_pkg::OP_BCAST: begin
                if (r_in.packet_kind == trnc_pkg::K_DISCOVER) begin
                    age_we = 1'b1;
                    age_wa = trnc_pkg::slot(r_in.packet_source);
                    age_wd = trnc_pkg::AGE_FULL;
                end
            end
            trnc_pkg::OP_UNI: begin
                age_we = 1'b1;
                age_wa = trnc_pkg::slot(r_in.from_address);
                age_wd = trnc_pkg::AGE_FULL;
                rt_re  = 1'b1;
                rt_ra  = trnc_pkg::slot(r_in.packet_dest);
                if (to_own && r_in.packet_kind == trnc_pkg::K_ACK) begin
                    rt_we = 1'b1;
                    rt_wa = trnc_pkg::slot(r_in.packet_source);
                    rt_wd = r_in.packet_source;
                end else if (!to_own && to_server) begin
                    rt_we = 1'b1;
                    rt_wa = trnc_pkg::slot(r_in.packet_source);
                    rt_wd = r_in.from_address;
                end
            end
            trnc_pkg::OP_UNI_HELLO: begin
                age_we = 1'b1;
                age_wa = trnc_pkg::slot(r_in.packet_source);
                age_wd = trnc_pkg::AGE_FULL;
            end
            default: begin
            end
        endcase
    end

    // packet emission for the current step
    always_comb begin
        e_valid = 1'b0;
        e_ent   = '0;
        case (i_cmd.op)
            trnc_pkg::OP_EMIT_DATA: begin
                e_valid = 1'b1;
                e_ent   = '{1'b0, r_parent, trnc_pkg::K_DATA, r_own, r_server,
                            r_in.sensor_value};
            end
            trnc_pkg::OP_ABANDON: begin
                e_valid = (cur_child != '0);
                e_ent   = '{1'b0, cur_child, trnc_pkg::K_ABANDON, r_own, cur_child, 16'd0};
            end
            trnc_pkg::OP_DISCOVER: begin
                e_valid = 1'b1;
                e_ent   = '{1'b1, '0, trnc_pkg::K_DISCOVER, r_own, '0, 16'd0};
            end
            trnc_pkg::OP_ROUND: begin
                e_valid = (n_round == 2'd0) && r_has;
                e_ent   = '{1'b0, r_parent, trnc_pkg::K_DATA, r_own, r_server,
                            r_in.sensor_value};
            end
            trnc_pkg::OP_BCAST: begin
                e_valid = (r_in.packet_kind == trnc_pkg::K_DISCOVER);
                e_ent   = '{1'b0, r_in.packet_source,
                            r_has ? trnc_pkg::K_HELLO_CHD : trnc_pkg::K_HELLO_ORP,
                            r_own, r_in.packet_source, 16'd0};
            end
            trnc_pkg::OP_UNI: begin
                if (to_own) begin
                    e_valid = (r_in.packet_kind == trnc_pkg::K_ADOPT) && !r_has;
                    e_ent   = '{1'b0, r_in.packet_source, trnc_pkg::K_ACK, r_own,
                                r_in.packet_source, 16'd0};
                end else if (to_server) begin
                    e_valid = 1'b1;
                    e_ent   = '{1'b0, r_parent, r_in.packet_kind, r_in.packet_source,
                                r_in.packet_dest, r_in.packet_payload};
                end
            end
            trnc_pkg::OP_UNI_HELLO: begin
                e_valid = r_has && (r_in.packet_kind == trnc_pkg::K_HELLO_ORP) && room &&
                          (r_parent != r_in.packet_source);
                e_ent   = '{1'b0, r_in.packet_source, trnc_pkg::K_ADOPT, r_own,
                            r_in.packet_source, 16'd0};
            end
            trnc_pkg::OP_RELAY: begin
                e_valid = 1'b1;
                e_ent   = '{1'b0, rt_rd, r_in.packet_kind, r_in.packet_source,
                            r_in.packet_dest, r_in.packet_payload};
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own    <= '0;
            r_server <= DW'(1);
            r_round  <= 2'd0;
            r_parent <= '0;
            r_has    <= 1'b0;
            r_valve  <= 1'b0;
            r_ccnt   <= '0;
            r_kept   <= '0;
            r_idx    <= '0;
            r_qcnt   <= '0;
            r_qrd    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.idx_rst) begin
                r_idx <= '0;
            end else if (i_cmd.op == trnc_pkg::OP_CLEAR || i_cmd.op == trnc_pkg::OP_AGE_WR ||
                         i_cmd.op == trnc_pkg::OP_CH_CHK || i_cmd.op == trnc_pkg::OP_ABANDON) begin
                r_idx <= r_idx + trnc_pkg::IDX_W'(1);
            end
            if (e_valid && r_qcnt < trnc_pkg::QCNT_W'(trnc_pkg::MAX_RES)) begin
                r_qcnt <= r_qcnt + trnc_pkg::QCNT_W'(1);
            end
            r_strobe <= (i_cmd.op == trnc_pkg::OP_DRAIN);
            case (i_cmd.op)
                trnc_pkg::OP_LATCH: begin
                    r_qcnt <= '0;
                    r_qrd  <= '0;
                    r_kept <= '0;
                end
                trnc_pkg::OP_CH_CHK: begin
                    if (age_rd != '0) begin
                        r_kept <= r_kept + trnc_pkg::CCNT_W'(1);
                    end
                end
                trnc_pkg::OP_CH_END: r_ccnt <= r_kept;
                trnc_pkg::OP_DROP_END: begin
                    r_ccnt   <= '0;
                    r_has    <= 1'b0;
                    r_parent <= '0;
                end
                trnc_pkg::OP_ROUND: r_round <= n_round;
                trnc_pkg::OP_UNI: begin
                    if (to_own) begin
                        case (r_in.packet_kind)
                            trnc_pkg::K_OPEN:  r_valve <= 1'b1;
                            trnc_pkg::K_CLOSE: r_valve <= 1'b0;
                            trnc_pkg::K_ACK: begin
                                if (!dup && room) begin
                                    r_ccnt <= r_ccnt + trnc_pkg::CCNT_W'(1);
                                end
                            end
                            trnc_pkg::K_ADOPT: begin
                                if (!r_has) begin
                                    r_has    <= 1'b1;
                                    r_parent <= r_in.packet_source;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                trnc_pkg::OP_DRAIN: r_qrd <= r_qrd + trnc_pkg::QIDX_W'(1);
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    trnc_pkg::CFG_OWN:    r_own    <= i_cfg_wdata;
                    trnc_pkg::CFG_SERVER: r_server <= i_cfg_wdata;
                    trnc_pkg::CFG_PHASE:
                        r_round <= (i_cfg_wdata[1:0] == 2'd3) ? 2'd0 : i_cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == trnc_pkg::OP_LATCH) begin
            r_in <= i_req;
        end
        if (i_cmd.op == trnc_pkg::OP_CH_CHK && age_rd != '0) begin
            r_child[r_kept[trnc_pkg::CHILD_AW-1:0]] <= cur_child;
        end
        if (i_cmd.op == trnc_pkg::OP_UNI && to_own && r_in.packet_kind == trnc_pkg::K_ACK &&
            !dup && room) begin
            r_child[r_ccnt[trnc_pkg::CHILD_AW-1:0]] <= r_in.packet_source;
        end
        if (e_valid && r_qcnt < trnc_pkg::QCNT_W'(trnc_pkg::MAX_RES)) begin
            r_q[r_qcnt[trnc_pkg::QIDX_W-1:0]] <= e_ent;
        end
        if (i_cmd.op == trnc_pkg::OP_DRAIN) begin
            if (r_qcnt == '0) begin
                r_res.send_valid   <= 1'b0;
                r_res.is_broadcast <= 1'b0;
                r_res.next_hop     <= '0;
                r_res.out_kind     <= '0;
                r_res.out_source   <= '0;
                r_res.out_dest     <= '0;
                r_res.out_payload  <= '0;
            end else begin
                r_res.send_valid   <= 1'b1;
                r_res.is_broadcast <= r_q[r_qrd].bcast;
                r_res.next_hop     <= r_q[r_qrd].hop;
                r_res.out_kind     <= r_q[r_qrd].kind;
                r_res.out_source   <= r_q[r_qrd].src;
                r_res.out_dest     <= r_q[r_qrd].dst;
                r_res.out_payload  <= r_q[r_qrd].pay;
            end
            r_res.valve_open   <= r_valve;
            r_res.parent_known <= r_has;
            r_res.last_result  <= q_last;
        end
    end

    assign o_stat.idx_end      = (r_idx == trnc_pkg::IDX_W'(trnc_pkg::NODE_SLOTS - 1));
    assign o_stat.ch_done      = (r_idx >= trnc_pkg::IDX_W'(r_ccnt));
    assign o_stat.age_zero     = (age_rd == '0);
    assign o_stat.parent_valid = r_has;
    assign o_stat.req_type     = r_in.req_type;
    assign o_stat.kind         = r_in.packet_kind;
    assign o_stat.to_own       = to_own;
    assign o_stat.to_server    = to_server;
    assign o_stat.q_last       = q_last;

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

endmodule

@@ rtl/trnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// trnc_ctrl
// Sequencer: steps the datapath through one transaction at a time.
// ----------------------------------------------------------------------------
module trnc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  trnc_pkg::t_stat i_stat,
    output trnc_pkg::t_cmd  o_cmd,
    output logic            busy
);

    typedef enum logic [15:0] {
        S_CLEAR     = 16'h0001,
        S_IDLE      = 16'h0002,
        S_DISPATCH  = 16'h0004,
        S_AGE_RD    = 16'h0008,
        S_AGE_WR    = 16'h0010,
        S_CH_RD     = 16'h0020,
        S_CH_CHK    = 16'h0040,
        S_PAR_RD    = 16'h0080,
        S_PAR_CHK   = 16'h0100,
        S_ABANDON   = 16'h0200,
        S_DISC      = 16'h0400,
        S_ROUND     = 16'h0800,
        S_UNI       = 16'h1000,
        S_UNI_HELLO = 16'h2000,
        S_RELAY     = 16'h4000,
        S_DRAIN     = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = trnc_pkg::OP_NOP;
        o_cmd.idx_rst = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = trnc_pkg::OP_CLEAR;
                if (i_stat.idx_end) begin
                    o_cmd.idx_rst = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op      = trnc_pkg::OP_LATCH;
                    o_cmd.idx_rst = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req_type)
                    trnc_pkg::REQ_TICK:   n_state = S_AGE_RD;
                    trnc_pkg::REQ_BUTTON: begin
                        o_cmd.op = trnc_pkg::OP_EMIT_DATA;
                        n_state  = S_AGE_RD;
                    end
                    trnc_pkg::REQ_BCAST: begin
                        o_cmd.op = trnc_pkg::OP_BCAST;
                        n_state  = S_DRAIN;
                    end
                    default: n_state = S_UNI;
                endcase
            end
            S_AGE_RD: begin
                o_cmd.op = trnc_pkg::OP_AGE_RD;
                n_state  = S_AGE_WR;
            end
            S_AGE_WR: begin
                o_cmd.op = trnc_pkg::OP_AGE_WR;
                if (i_stat.idx_end) begin
                    o_cmd.idx_rst = 1'b1;
                    n_state       = S_CH_RD;
                end else begin
                    n_state = S_AGE_RD;
                end
            end
            S_CH_RD: begin
                if (i_stat.ch_done) begin
                    o_cmd.op = trnc_pkg::OP_CH_END;
                    n_state  = S_PAR_RD;
                end else begin
                    o_cmd.op = trnc_pkg::OP_CH_RD;
                    n_state  = S_CH_CHK;
                end
            end
            S_CH_CHK: begin
                o_cmd.op = trnc_pkg::OP_CH_CHK;
                n_state  = S_CH_RD;
            end
            S_PAR_RD: begin
                o_cmd.idx_rst = 1'b1;
                if (i_stat.parent_valid) begin
                    o_cmd.op = trnc_pkg::OP_PAR_RD;
                    n_state  = S_PAR_CHK;
                end else begin
                    n_state = S_DISC;
                end
            end
            S_PAR_CHK: n_state = i_stat.age_zero ? S_ABANDON : S_DISC;
            S_ABANDON: begin
                if (i_stat.ch_done) begin
                    o_cmd.op      = trnc_pkg::OP_DROP_END;
                    o_cmd.idx_rst = 1'b1;
                    n_state = (i_stat.req_type == trnc_pkg::REQ_UCAST) ? S_DRAIN : S_DISC;
                end else begin
                    o_cmd.op = trnc_pkg::OP_ABANDON;
                end
            end
            S_DISC: begin
                o_cmd.op = trnc_pkg::OP_DISCOVER;
                n_state  = (i_stat.req_type == trnc_pkg::REQ_TICK) ? S_ROUND : S_DRAIN;
            end
            S_ROUND: begin
                o_cmd.op = trnc_pkg::OP_ROUND;
                n_state  = S_DRAIN;
            end
            S_UNI: begin
                o_cmd.op = trnc_pkg::OP_UNI;
                if (i_stat.to_own) begin
                    if (i_stat.kind == trnc_pkg::K_HELLO_ORP ||
                        i_stat.kind == trnc_pkg::K_HELLO_CHD) begin
                        n_state = S_UNI_HELLO;
                    end else if (i_stat.kind == trnc_pkg::K_ABANDON) begin
                        n_state = S_ABANDON;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end else if (i_stat.to_server) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_RELAY;
                end
            end
            S_UNI_HELLO: begin
                o_cmd.op = trnc_pkg::OP_UNI_HELLO;
                n_state  = S_DRAIN;
            end
            S_RELAY: begin
                o_cmd.op = trnc_pkg::OP_RELAY;
                n_state  = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.op = trnc_pkg::OP_DRAIN;
                if (i_stat.q_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ rtl/tree_routing_node_controller_core.sv @@
// Before the first result, a tick or button press walks the age table, child filter and
//   parent check, plus the abandon pass when the parent ages out; broadcast, unicast, hello,
//   relay and abandon requests skip the age walk and run only their own receive branch.
// Throughput: results then follow one per cycle, up to six; the next start is taken at the
//   edge that ends the last result. One transaction in flight at a time.
// Reset: a clearing pass over all 256 slots zeroes the age and route tables (busy high); config
//   writes are taken during it. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// tree_routing_node_controller_core
// Tree-forming mesh node controller: sequencer plus datapath.
// ----------------------------------------------------------------------------
`include "tree_routing_node_controller_core_macros.svh"

module tree_routing_node_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // transaction request
    input  logic                           start,
    output logic                           busy,
    input  trnc_pkg::t_req                 i_req,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [trnc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                    i_cfg_wdata,
    // results, one per cycle, qualified by o_strobe
    output trnc_pkg::t_res                 o_res,
    output logic                           o_strobe
);

    trnc_pkg::t_cmd  cmd;
    trnc_pkg::t_stat stat;

    // the sequencer walks: age table, child filter, parent check, abandon,
    // discover, round/data, or the receive branch, then drains the queue
    trnc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .busy   (busy)
    );

    // results are queued during the transaction so valve/parent flags
    // carry their final values on every result
    trnc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res),
        .o_strobe   (o_strobe)
    );

    `TRNC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `TRNC_ASSERT_SAME(a_strobe_busy, o_strobe, $past(busy), "result outside a transaction")
    `TRNC_ASSERT_NEXT(a_last_ends, o_strobe && o_res.last_result, !o_strobe,
                      "result after last")
    `TRNC_ASSERT_SAME(a_empty_last, o_strobe && !o_res.send_valid, o_res.last_result,
                      "empty result not last")

endmodule
